/* rtl/core/dast_pkg.sv */
// ---------------------------------------------------------------------------
// Daily alarm schedule table: shared definitions
// Entry, request and evaluation types, op and status codes, sequencer states.
// ---------------------------------------------------------------------------
package dast_pkg;

    localparam int OP_W     = 3;
    localparam int MINUTE_W = 11;
    localparam int ID_W     = 8;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int STATUS_W = 2;
    localparam int TIME_W   = 12;

    localparam logic [TIME_W-1:0] MINUTES_PER_HOUR = 12'd60;

    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_TOGGLE = 3'd3;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_FIRED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    localparam logic [ID_W-1:0] NEXT_ID_RESET = 8'd1;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [HOUR_W-1:0]   hour;
        logic [MIN_W-1:0]    minute;
        logic                enabled;
        logic                rpt;
        logic                has_fired;
        logic [MINUTE_W-1:0] last_fired;
    } t_entry;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [MINUTE_W-1:0] minute_now;
        logic [ID_W-1:0]     entry_id;
        logic [HOUR_W-1:0]   hour_of_day;
        logic [MIN_W-1:0]    minute_of_hour;
        logic                enable_flag;
        logic                repeat_flag;
    } t_req;

    typedef struct packed {
        logic   match;
        logic   fire;
        t_entry tick_entry;
        t_entry edit_entry;
    } t_eval;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ADD,
        S_FIND,
        S_SHIFT,
        S_FINISH
    } t_state;

endpackage

/* rtl/core/dast_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module dast_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/dast_eval.sv */
// ---------------------------------------------------------------------------
// Entry evaluation unit
// Judges one stored entry against the current request: id match, firing
// decision for a tick, and the rewritten entry for tick, toggle and update.
// ---------------------------------------------------------------------------
module dast_eval
    import dast_pkg::*;
(
    input  t_req   i_req,
    input  t_entry i_entry,
    output t_eval  o_eval
);

    logic [TIME_W-1:0] w_alarm_time;
    logic [TIME_W-1:0] w_now;
    logic [TIME_W-1:0] w_last_next;
    logic              w_skip;
    logic              w_fire;
    logic              w_expire;
    t_entry            w_tick;
    t_entry            w_edit;

    assign w_alarm_time = {{(TIME_W-HOUR_W){1'b0}}, i_entry.hour} * MINUTES_PER_HOUR
                        + {{(TIME_W-MIN_W){1'b0}}, i_entry.minute};
    assign w_now        = {{(TIME_W-MINUTE_W){1'b0}}, i_req.minute_now};
    assign w_last_next  = {{(TIME_W-MINUTE_W){1'b0}}, i_entry.last_fired} + 12'd1;

    // An entry that already fired in this very minute is left alone.
    assign w_skip   = !i_entry.enabled
                   || (i_entry.has_fired && (i_entry.last_fired == i_req.minute_now));
    assign w_fire   = !w_skip && (w_alarm_time == w_now);
    assign w_expire = !w_skip && !w_fire && !i_entry.rpt && i_entry.has_fired
                   && (w_now > w_last_next);

    always_comb begin
        w_tick = i_entry;
        if (w_fire) begin
            w_tick.last_fired = i_req.minute_now;
            w_tick.has_fired  = 1'b1;
            if (!i_entry.rpt) begin
                w_tick.enabled = 1'b0;
            end
        end else if (w_expire) begin
            w_tick.enabled = 1'b0;
        end
    end

    always_comb begin
        w_edit         = i_entry;
        w_edit.enabled = i_req.enable_flag;
        if (i_req.op == OP_UPDATE) begin
            w_edit.hour   = i_req.hour_of_day;
            w_edit.minute = i_req.minute_of_hour;
            w_edit.rpt    = i_req.repeat_flag;
        end
    end

    assign o_eval.match      = (i_entry.id == i_req.entry_id);
    assign o_eval.fire       = w_fire;
    assign o_eval.tick_entry = w_tick;
    assign o_eval.edit_entry = w_edit;

endmodule

/* rtl/core/dast_ctrl.sv */
// ---------------------------------------------------------------------------
// Schedule table sequencer
// Walks the table one entry per cycle through the RAM read port, applies the
// evaluation result through the write port, and registers every result.
// ---------------------------------------------------------------------------
module dast_ctrl
    import dast_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    localparam int AW         = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int CW         = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  t_req                i_req,
    output logic                o_busy,
    output t_req                o_req,
    input  t_entry              i_rd_entry,
    input  t_eval               i_eval,
    output logic [AW-1:0]       o_raddr,
    output logic                o_we,
    output logic [AW-1:0]       o_waddr,
    output t_entry              o_wdata,
    output logic                o_strobe,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_result_id,
    output logic                o_last_item
);

    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);

    t_state              r_state, n_state;
    t_req                r_req, n_req;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [AW-1:0]       r_widx, n_widx;
    logic [ID_W-1:0]     r_next_id, n_next_id;
    logic                r_strobe, n_strobe;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [ID_W-1:0]     r_result_id, n_result_id;
    logic                r_last_item, n_last_item;

    logic                w_more;
    logic                w_drained;
    logic [ID_W-1:0]     w_add_id;
    t_entry              w_new_entry;

    // r_pend says the RAM output holds entry r_widx, read in the last cycle.
    assign w_more    = (r_idx < r_count);
    assign w_drained = !r_pend && !w_more;

    assign w_add_id = (r_req.entry_id == '0) ? r_next_id : r_req.entry_id;

    always_comb begin
        w_new_entry            = '0;
        w_new_entry.id         = w_add_id;
        w_new_entry.hour       = r_req.hour_of_day;
        w_new_entry.minute     = r_req.minute_of_hour;
        w_new_entry.enabled    = r_req.enable_flag;
        w_new_entry.rpt        = r_req.repeat_flag;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_req.op)
                        OP_TICK:                          n_state = S_SCAN;
                        OP_ADD:                           n_state = S_ADD;
                        OP_REMOVE, OP_TOGGLE, OP_UPDATE:  n_state = S_FIND;
                        default:                          n_state = S_FINISH;
                    endcase
                end
            end
            S_SCAN, S_SHIFT: begin
                if (w_drained) begin
                    n_state = S_IDLE;
                end
            end
            S_FIND: begin
                if (r_pend && i_eval.match) begin
                    n_state = (r_req.op == OP_REMOVE) ? S_SHIFT : S_IDLE;
                end else if (w_drained) begin
                    n_state = S_IDLE;
                end
            end
            S_ADD, S_FINISH: n_state = S_IDLE;
            default:         n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_req       = r_req;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_widx      = r_widx;
        n_next_id   = r_next_id;
        n_strobe    = 1'b0;
        n_status    = ST_OK;
        n_result_id = '0;
        n_last_item = 1'b1;
        o_raddr     = r_idx[AW-1:0];
        o_we        = 1'b0;
        o_waddr     = r_widx;
        o_wdata     = i_rd_entry;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    n_idx = '0;
                end
            end
            S_SCAN: begin
                if (r_pend) begin
                    o_we    = 1'b1;
                    o_wdata = i_eval.tick_entry;
                    if (i_eval.fire) begin
                        n_strobe    = 1'b1;
                        n_status    = ST_FIRED;
                        n_result_id = i_rd_entry.id;
                        n_last_item = 1'b0;
                    end
                end
                if (w_more) begin
                    n_pend = 1'b1;
                    n_widx = r_idx[AW-1:0];
                    n_idx  = r_idx + 1'b1;
                end
                if (w_drained) begin
                    n_strobe = 1'b1;
                end
            end
            S_ADD: begin
                n_strobe = 1'b1;
                if (r_count == FULL_COUNT) begin
                    n_status = ST_FULL;
                end else begin
                    o_we        = 1'b1;
                    o_waddr     = r_count[AW-1:0];
                    o_wdata     = w_new_entry;
                    n_count     = r_count + 1'b1;
                    n_result_id = w_add_id;
                    if ((r_req.entry_id == '0) || (r_req.entry_id >= r_next_id)) begin
                        n_next_id = w_add_id + 1'b1;
                    end
                end
            end
            S_FIND: begin
                if (r_pend && i_eval.match) begin
                    if (r_req.op == OP_REMOVE) begin
                        // Entries behind the match move down one slot each.
                        n_idx = CW'(r_widx) + 1'b1;
                    end else begin
                        o_we     = 1'b1;
                        o_wdata  = i_eval.edit_entry;
                        n_strobe = 1'b1;
                    end
                end else begin
                    if (w_more) begin
                        n_pend = 1'b1;
                        n_widx = r_idx[AW-1:0];
                        n_idx  = r_idx + 1'b1;
                    end
                    if (w_drained) begin
                        n_strobe = 1'b1;
                        n_status = ST_NOTFOUND;
                    end
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    o_we    = 1'b1;
                    o_waddr = r_widx - 1'b1;
                end
                if (w_more) begin
                    n_pend = 1'b1;
                    n_widx = r_idx[AW-1:0];
                    n_idx  = r_idx + 1'b1;
                end
                if (w_drained) begin
                    n_count  = r_count - 1'b1;
                    n_strobe = 1'b1;
                end
            end
            S_FINISH: begin
                n_strobe = 1'b1;
                if (r_req.op == OP_CLEAR) begin
                    n_count = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_next_id <= NEXT_ID_RESET;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_next_id <= n_next_id;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_idx       <= n_idx;
        r_widx      <= n_widx;
        r_status    <= n_status;
        r_result_id <= n_result_id;
        r_last_item <= n_last_item;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_req       = r_req;
    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_result_id = r_result_id;
    assign o_last_item = r_last_item;

endmodule

/* rtl/core/daily_alarm_schedule_table.sv */
// ---------------------------------------------------------------------------
// Daily alarm schedule table
// Ordered table of daily alarms with add, remove, toggle, update, clear and
// a minute tick that reports every alarm firing in that minute.
// ---------------------------------------------------------------------------
//
//  channel   handshake            payload
//  request   start / busy         i_op, i_minute_now, i_entry_id, i_hour_of_day,
//                                 i_minute_of_hour, i_enable_flag, i_repeat_flag
//  result    o_strobe (1 cycle)   o_status, o_result_id, o_last_item
//
// A request is taken when start is high and busy is low. A tick holds busy while it
// makes one RAM read per entry through the shared evaluation unit; toggle, update and
// an unknown id search the table (S_FIND), remove also shifts the entries behind the
// match (S_SHIFT), and add, clear and the spare codes only pass S_ADD or S_FINISH.
// Reset empties the table at once (fill count) and sets the next id to one. Results
// cannot be stalled: each is shown for one cycle, the last one with busy already low.
module daily_alarm_schedule_table
    import dast_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     i_op,
    input  logic [MINUTE_W-1:0] i_minute_now,
    input  logic [ID_W-1:0]     i_entry_id,
    input  logic [HOUR_W-1:0]   i_hour_of_day,
    input  logic [MIN_W-1:0]    i_minute_of_hour,
    input  logic                i_enable_flag,
    input  logic                i_repeat_flag,
    output logic                o_strobe,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_result_id,
    output logic                o_last_item
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    t_req            w_in_req;
    t_req            w_req;
    t_entry          w_rd_entry;
    t_entry          w_wdata;
    t_eval           w_eval;
    logic [AW-1:0]   w_raddr;
    logic [AW-1:0]   w_waddr;
    logic            w_we;

    assign w_in_req.op             = i_op;
    assign w_in_req.minute_now     = i_minute_now;
    assign w_in_req.entry_id       = i_entry_id;
    assign w_in_req.hour_of_day    = i_hour_of_day;
    assign w_in_req.minute_of_hour = i_minute_of_hour;
    assign w_in_req.enable_flag    = i_enable_flag;
    assign w_in_req.repeat_flag    = i_repeat_flag;

    dast_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (w_in_req),
        .o_busy      (busy),
        .o_req       (w_req),
        .i_rd_entry  (w_rd_entry),
        .i_eval      (w_eval),
        .o_raddr     (w_raddr),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_result_id (o_result_id),
        .o_last_item (o_last_item)
    );

    dast_eval u_eval (
        .i_req   (w_req),
        .i_entry (w_rd_entry),
        .o_eval  (w_eval)
    );

    dast_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_entry)
    );

endmodule

/* sim/tb_daily_alarm_schedule_table.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench: daily alarm schedule table
// Sends directed and random table edits and minute ticks through the
// start/busy port. A scoreboard predicts every result and checks each strobe.
// ---------------------------------------------------------------------------
module tb_daily_alarm_schedule_table;
    import dast_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 235;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_PERCENT = 28;

    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     result_id;
        logic                last_item;
    } t_answer;

    class alarm_table_scoreboard;
        t_entry          entries[TABLE_DEPTH];
        int              fill;
        logic [ID_W-1:0] next_id;
        t_answer         pending_answers[$];
        int              errors;
        int              requests;
        int              ticks;
        int              firings;
        int              full_hits;
        int              misses;

        function new();
            fill      = 0;
            next_id   = NEXT_ID_RESET;
            errors    = 0;
            requests  = 0;
            ticks     = 0;
            firings   = 0;
            full_hits = 0;
            misses    = 0;
        endfunction

        function void push_answer(logic [STATUS_W-1:0] st, logic [ID_W-1:0] id,
                                  logic last_item);
            t_answer a;
            a.status    = st;
            a.result_id = id;
            a.last_item = last_item;
            pending_answers = {pending_answers, a};
        endfunction

        function int find_id(logic [ID_W-1:0] id);
            for (int i = 0; i < fill; i++)
                if (entries[i].id == id) return i;
            return -1;
        endfunction

        function void take_request(t_req r);
            int     slot;
            int     now;
            int     due;
            t_entry e;
            requests++;
            case (r.op)
                OP_TICK: begin
                    ticks++;
                    now = int'(r.minute_now);
                    for (int i = 0; i < fill; i++) begin
                        e = entries[i];
                        if (!e.enabled) continue;
                        if (e.has_fired && int'(e.last_fired) == now) continue;
                        due = int'(e.hour) * int'(MINUTES_PER_HOUR) + int'(e.minute);
                        if (due == now) begin
                            e.last_fired = r.minute_now;
                            e.has_fired  = 1'b1;
                            if (!e.rpt) e.enabled = 1'b0;
                            push_answer(ST_FIRED, e.id, 1'b0);
                            firings++;
                        end else if (!e.rpt && e.has_fired &&
                                     now > int'(e.last_fired) + 1) begin
                            // A one-shot alarm is retired once a tick comes over a minute after its last firing.
                            e.enabled = 1'b0;
                        end
                        entries[i] = e;
                    end
                    push_answer(ST_OK, '0, 1'b1);
                end
                OP_ADD: begin
                    if (fill >= TABLE_DEPTH) begin
                        full_hits++;
                        push_answer(ST_FULL, '0, 1'b1);
                    end else begin
                        e.id = r.entry_id;
                        if (r.entry_id == '0) begin
                            e.id    = next_id;
                            next_id = next_id + 1'b1;
                        end else if (r.entry_id >= next_id) begin
                            next_id = r.entry_id + 1'b1;
                        end
                        e.hour       = r.hour_of_day;
                        e.minute     = r.minute_of_hour;
                        e.enabled    = r.enable_flag;
                        e.rpt        = r.repeat_flag;
                        e.has_fired  = 1'b0;
                        e.last_fired = '0;
                        entries[fill] = e;
                        fill++;
                        push_answer(ST_OK, e.id, 1'b1);
                    end
                end
                OP_REMOVE, OP_TOGGLE, OP_UPDATE: begin
                    slot = find_id(r.entry_id);
                    if (slot < 0) begin
                        misses++;
                        push_answer(ST_NOTFOUND, '0, 1'b1);
                    end else begin
                        if (r.op == OP_REMOVE) begin
                            for (int i = slot; i + 1 < fill; i++)
                                entries[i] = entries[i + 1];
                            fill--;
                        end else if (r.op == OP_TOGGLE) begin
                            entries[slot].enabled = r.enable_flag;
                        end else begin
                            entries[slot].hour    = r.hour_of_day;
                            entries[slot].minute  = r.minute_of_hour;
                            entries[slot].enabled = r.enable_flag;
                            entries[slot].rpt     = r.repeat_flag;
                        end
                        push_answer(ST_OK, '0, 1'b1);
                    end
                end
                OP_CLEAR: begin
                    fill = 0;
                    push_answer(ST_OK, '0, 1'b1);
                end
                default: begin
                    push_answer(ST_OK, '0, 1'b1);
                end
            endcase
        endfunction

        function void check_response(logic [STATUS_W-1:0] status,
                                     logic [ID_W-1:0] result_id, logic last_item);
            t_answer want;
            if (pending_answers.size() == 0) begin
                $error("Unexpected result: status %0d, result_id %0d, last_item %0d",
                       status, result_id, last_item);
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (result_id !== want.result_id) begin
                $error("result_id: expected %0d, got %0d", want.result_id, result_id);
                errors++;
            end
            if (last_item !== want.last_item) begin
                $error("last_item: expected %0d, got %0d", want.last_item, last_item);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     i_op;
    logic [MINUTE_W-1:0] i_minute_now;
    logic [ID_W-1:0]     i_entry_id;
    logic [HOUR_W-1:0]   i_hour_of_day;
    logic [MIN_W-1:0]    i_minute_of_hour;
    logic                i_enable_flag;
    logic                i_repeat_flag;
    logic                o_strobe;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_result_id;
    logic                o_last_item;

    alarm_table_scoreboard board;
    bit                    idling_on;
    int                    cycle_count = 0;

    daily_alarm_schedule_table #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_minute_now    (i_minute_now),
        .i_entry_id      (i_entry_id),
        .i_hour_of_day   (i_hour_of_day),
        .i_minute_of_hour(i_minute_of_hour),
        .i_enable_flag   (i_enable_flag),
        .i_repeat_flag   (i_repeat_flag),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_result_id     (o_result_id),
        .o_last_item     (o_last_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Results are checked before a request taken at the same edge is noted,
    // which keeps the expected results in request order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) board.check_response(o_status, o_result_id, o_last_item);
            if (start && !busy)
                board.take_request({i_op, i_minute_now, i_entry_id, i_hour_of_day,
                                    i_minute_of_hour, i_enable_flag, i_repeat_flag});
        end
    end

    function automatic t_req random_fields();
        t_req r;
        r.op             = 3'($urandom);
        r.minute_now     = 11'($urandom);
        r.entry_id       = 8'($urandom);
        r.hour_of_day    = 5'($urandom);
        r.minute_of_hour = 6'($urandom);
        r.enable_flag    = 1'($urandom);
        r.repeat_flag    = 1'($urandom);
        return r;
    endfunction

    task automatic put_fields(input t_req r);
        i_op             <= r.op;
        i_minute_now     <= r.minute_now;
        i_entry_id       <= r.entry_id;
        i_hour_of_day    <= r.hour_of_day;
        i_minute_of_hour <= r.minute_of_hour;
        i_enable_flag    <= r.enable_flag;
        i_repeat_flag    <= r.repeat_flag;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic drive_request(input t_req r);
        if (idling_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            start <= 1'b0;
            put_fields(random_fields());
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        start <= 1'b1;
        put_fields(r);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic issue(input logic [OP_W-1:0] op, input int now, input int id,
                         input int hr, input int mn, input bit en, input bit rp);
        t_req r;
        r.op             = op;
        r.minute_now     = 11'(now);
        r.entry_id       = 8'(id);
        r.hour_of_day    = 5'(hr);
        r.minute_of_hour = 6'(mn);
        r.enable_flag    = en;
        r.repeat_flag    = rp;
        drive_request(r);
    endtask

    task automatic issue_spare(input logic [OP_W-1:0] op);
        t_req r;
        r    = random_fields();
        r.op = op;
        drive_request(r);
    endtask

    function automatic t_req make_random(input bit only_add);
        t_req r;
        int   pick;
        int   slot;
        int   base;
        r    = random_fields();
        pick = $urandom_range(0, 99);
        if (only_add || pick < 40) r.op = OP_ADD;
        else if (pick < 70) r.op = OP_TICK;
        else if (pick < 77) r.op = OP_REMOVE;
        else if (pick < 85) r.op = OP_TOGGLE;
        else if (pick < 93) r.op = OP_UPDATE;
        else if (pick < 94) r.op = OP_CLEAR;
        else r.op = pick[0] ? OP_SPARE_6 : OP_SPARE_7;
        slot = (board.fill > 0) ? int'($urandom_range(0, board.fill - 1)) : -1;
        // Alarm times are mostly packed into a few minutes so ticks hit them.
        if ($urandom_range(0, 3) != 0) begin
            r.hour_of_day    = 5'($urandom_range(0, 1));
            r.minute_of_hour = 6'($urandom_range(0, 3));
        end
        r.enable_flag = ($urandom_range(0, 3) != 0);
        case (r.op)
            OP_ADD: begin
                pick = $urandom_range(0, 99);
                if (pick < 45) r.entry_id = '0;
                else if (pick < 80) r.entry_id = 8'($urandom_range(1, 12));
            end
            OP_REMOVE, OP_TOGGLE, OP_UPDATE: begin
                if (slot >= 0 && $urandom_range(0, 3) != 0)
                    r.entry_id = board.entries[slot].id;
            end
            OP_TICK: begin
                if (slot >= 0 && $urandom_range(0, 99) < 80) begin
                    base = int'(board.entries[slot].hour) * int'(MINUTES_PER_HOUR)
                         + int'(board.entries[slot].minute);
                    if ($urandom_range(0, 3) == 0) base += $urandom_range(1, 2);
                    r.minute_now = 11'(base);
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    initial begin
        t_req r;
        board            = new();
        idling_on        = 1'b1;
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_op             = OP_TICK;
        i_minute_now     = '0;
        i_entry_id       = '0;
        i_hour_of_day    = '0;
        i_minute_of_hour = '0;
        i_enable_flag    = 1'b0;
        i_repeat_flag    = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        issue(OP_TICK,      0,   0,  0,  0, 1'b0, 1'b0);  // empty table
        issue(OP_ADD,       0,   0,  0,  0, 1'b1, 1'b1);  // takes id 1
        issue(OP_ADD,       0, 255, 23, 59, 1'b1, 1'b0);  // next id wraps to 0
        issue(OP_ADD,       0,   0,  0,  0, 1'b1, 1'b0);  // takes id 0
        issue(OP_ADD,       0, 200, 31, 63, 1'b1, 1'b1);  // out-of-range time
        issue(OP_ADD,       0,   7,  0,  1, 1'b0, 1'b1);
        issue(OP_TICK,      0,   0,  0,  0, 1'b0, 1'b0);  // two fire
        issue(OP_TICK,      0,   0,  0,  0, 1'b0, 1'b0);  // same minute again
        issue(OP_TICK,   1439,   0,  0,  0, 1'b0, 1'b0);
        issue(OP_TOGGLE,    0,   0,  0,  0, 1'b1, 1'b0);
        issue(OP_TICK,      1,   0,  0,  0, 1'b0, 1'b0);  // one minute late: kept
        issue(OP_TICK,      2,   0,  0,  0, 1'b0, 1'b0);  // later: one-shot retired
        issue(OP_TOGGLE,    0,   7,  0,  0, 1'b1, 1'b0);
        issue(OP_TICK,      1,   0,  0,  0, 1'b0, 1'b0);
        issue(OP_UPDATE,    0,   1,  0,  2, 1'b1, 1'b0);  // keeps firing record
        issue(OP_TICK,      2,   0,  0,  0, 1'b0, 1'b0);
        issue(OP_TICK,   1923,   0,  0,  0, 1'b0, 1'b0);
        issue(OP_TICK,   2047,   0,  0,  0, 1'b0, 1'b0);
        issue(OP_REMOVE,    0,  99,  0,  0, 1'b0, 1'b0);
        issue(OP_TOGGLE,    0,  99,  0,  0, 1'b1, 1'b0);
        issue(OP_UPDATE,    0,  99,  5,  5, 1'b1, 1'b1);
        issue(OP_REMOVE,    0,   1,  0,  0, 1'b0, 1'b0);  // first entry: the rest shift down
        issue_spare(OP_SPARE_6);
        issue_spare(OP_SPARE_7);
        issue(OP_CLEAR,     0,   0,  0,  0, 1'b0, 1'b0);

        // The random part opens with a run of adds that overfills the table.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idling_on = !(n >= 120 && n < 190);
            r = make_random(n < 20);
            drive_request(r);
        end
        start <= 1'b0;

        while (board.pending_answers.size() != 0 || busy) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Ran %0d requests: %0d ticks with %0d alarm firings,", board.requests,
                 board.ticks, board.firings);
        $display("%0d full-table and %0d unknown-id answers, %0d mismatches.",
                 board.full_hits, board.misses, board.errors);
        if (board.errors == 0 && board.pending_answers.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
